FILE: rtl/core/register_busy_map_with_snapshots_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the register busy map
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef REGISTER_BUSY_MAP_WITH_SNAPSHOTS_TOP_ASSERT_SVH
`define REGISTER_BUSY_MAP_WITH_SNAPSHOTS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Check cons in the same cycle as ante.
`define RBMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("busy map assertion failed");

// Check cons in the cycle after ante.
`define RBMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("busy map assertion failed");

`else

`define RBMS_ASSERT_SAME(label, clk, rst, ante, cons)
`define RBMS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/rbms_pkg.sv
// ----------------------------------------------------------------------------
// Register busy map package
// Field widths, operation codes and item payload types.
// ----------------------------------------------------------------------------
package rbms_pkg;

   localparam int MAP_W = 15;          // busy bits, registers 0 to 14
   localparam int REG_W = 4;           // register index width
   localparam int OP_W  = 3;
   localparam int SLOT_W = 2 ** REG_W; // every code of a register index

   localparam int ACTIVE_REGS_DEFAULT = 15;
   localparam int SAVE_DEPTH_DEFAULT  = 8;

   localparam logic [REG_W-1:0] RELOAD_REG = REG_W'(10);
   localparam logic [REG_W-1:0] SPILL_REG  = REG_W'(1);
   localparam logic [MAP_W-1:0] LOW_SEVEN  = MAP_W'(16'h00FE);

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 3'd0,
      OP_ALLOC   = 3'd1,
      OP_CLAIM   = 3'd2,
      OP_RELEASE = 3'd3,
      OP_SAVE    = 3'd4,
      OP_RESTORE = 3'd5
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [REG_W-1:0] reg_index;
   } req_payload_type;

   typedef struct packed {
      logic [REG_W-1:0] granted_reg;
      logic             success;
      logic             spill_flag;
      logic             reload_flag;
      logic             stack_error;
   } rsp_payload_type;

endpackage

FILE: rtl/core/rbms_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One item moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface rbms_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/register_busy_map_with_snapshots_top.sv
// ----------------------------------------------------------------------------
// Register busy map with snapshot stack
// Each accepted item's result item is registered in the output register.
// Throughput: 1 item per cycle while the consumer takes results; the busy map and stack level registers close the loop.
// The output register holds a result while the consumer stalls; req ready tracks it.
// Reset (synchronous, active high): map all free, stack empty, output empty.
// Saved map entries are undefined until a save writes them.
// ----------------------------------------------------------------------------
`include "register_busy_map_with_snapshots_top_assert.svh"

module register_busy_map_with_snapshots_top #(
   parameter int ACTIVE_REGS = rbms_pkg::ACTIVE_REGS_DEFAULT,  // 11 to 15
   parameter int SAVE_DEPTH  = rbms_pkg::SAVE_DEPTH_DEFAULT    // 1 to 15
) (
   input logic          clock,
   input logic          reset,
   rbms_stream_if.sink   req_if,
   rbms_stream_if.source rsp_if
);
   import rbms_pkg::*;

   // Stack level counts 0..SAVE_DEPTH; the entry index needs one code less.
   localparam int LVL_W = $clog2(SAVE_DEPTH + 1);
   localparam int IDX_W = (SAVE_DEPTH > 1) ? $clog2(SAVE_DEPTH) : 1;

   // Registers 1 to ACTIVE_REGS-1: the set that clear frees and allocate scans.
   function automatic logic [MAP_W-1:0] make_active_mask();
      logic [MAP_W-1:0] m;
      m = '0;
      for (int r = 1; r < MAP_W; r++) begin
         if (r < ACTIVE_REGS) m[r] = 1'b1;
      end
      return m;
   endfunction

   localparam logic [MAP_W-1:0]  ACTIVE_MASK = make_active_mask();
   // Release is legal only for active registers; the top code has no bit.
   localparam logic [SLOT_W-1:0] RELEASE_OK  = SLOT_W'(ACTIVE_MASK);
   localparam logic [LVL_W-1:0]  LVL_FULL    = LVL_W'(SAVE_DEPTH);

   // Lowest free register among the active ones, zero if none.
   function automatic logic [REG_W-1:0] lowest_free(input logic [MAP_W-1:0] map);
      logic [REG_W-1:0] pick;
      pick = '0;
      for (int r = MAP_W - 1; r >= 1; r--) begin
         if (ACTIVE_MASK[r] && !map[r]) pick = REG_W'(r);
      end
      return pick;
   endfunction

   // State
   logic [MAP_W-1:0] busy_ff, busy_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [MAP_W-1:0] saved_ff [SAVE_DEPTH];

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic             accept;
   logic             save_wr;
   logic [LVL_W-1:0] level_dec;
   logic [REG_W-1:0] free_reg;
   logic [SLOT_W-1:0] busy_slots;
   logic [SLOT_W-1:0] claim_slots;
   req_payload_type  req;

   // Take a new item whenever the output register is empty or being drained.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign req          = req_if.payload;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   assign level_dec  = level_ff - LVL_W'(1);
   assign free_reg   = lowest_free(busy_ff);
   // Register 15 has no bit: treat it as always busy so a claim fails.
   assign busy_slots = {1'b1, busy_ff};
   assign claim_slots = busy_slots | (SLOT_W'(1) << req.reg_index);

   always_comb begin
      busy_in  = busy_ff;
      level_in = level_ff;
      save_wr  = 1'b0;
      rsp_in   = '0;

      case (req.operation)
         OP_CLEAR: begin
            busy_in        = busy_ff & ~ACTIVE_MASK;
            rsp_in.success = 1'b1;
         end
         OP_ALLOC: begin
            rsp_in.success = 1'b1;
            if (free_reg != '0) begin
               busy_in            = busy_ff | (MAP_W'(1) << free_reg);
               rsp_in.granted_reg = free_reg;
            end else begin
               // Spill registers 1 to 7 and hand out register 1.
               busy_in            = (busy_ff & ~LOW_SEVEN) | (MAP_W'(1) << SPILL_REG);
               rsp_in.granted_reg = SPILL_REG;
               rsp_in.spill_flag  = 1'b1;
            end
         end
         OP_CLAIM: begin
            if (!busy_slots[req.reg_index]) begin
               busy_in        = claim_slots[MAP_W-1:0];
               rsp_in.success = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (RELEASE_OK[req.reg_index]) begin
               busy_in        = busy_ff & ~(MAP_W'(1) << req.reg_index);
               rsp_in.success = 1'b1;
            end
            // Releasing the reload register marks 1 to 7 busy again.
            if (req.reg_index == RELOAD_REG) begin
               busy_in            = (busy_ff & ~(MAP_W'(1) << RELOAD_REG)) | LOW_SEVEN;
               rsp_in.success     = 1'b1;
               rsp_in.reload_flag = 1'b1;
            end
         end
         OP_SAVE: begin
            if (level_ff < LVL_FULL) begin
               save_wr        = 1'b1;
               level_in       = level_ff + LVL_W'(1);
               rsp_in.success = 1'b1;
            end else begin
               rsp_in.stack_error = 1'b1;
            end
         end
         OP_RESTORE: begin
            if (level_ff != '0) begin
               level_in       = level_dec;
               busy_in        = saved_ff[level_dec[IDX_W-1:0]];
               rsp_in.success = 1'b1;
            end else begin
               rsp_in.stack_error = 1'b1;
            end
         end
         default: begin
            // Unused codes: leave state alone, all result fields zero.
         end
      endcase
   end

   // Hold the result until taken; load a new one on accept.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            busy_ff  <= busy_in;
            level_ff <= level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
      if (accept && save_wr) begin
         saved_ff[level_ff[IDX_W-1:0]] <= busy_ff;
      end
   end

   // Stack never runs past its depth.
   `RBMS_ASSERT_SAME(a_level_bound, clock, reset, 1'b1, level_ff <= LVL_FULL)
   // Spill and reload come from different operations.
   `RBMS_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_valid_ff,
                     !(rsp_ff.spill_flag && rsp_ff.reload_flag))
   // A granted register is busy right after the allocate.
   `RBMS_ASSERT_NEXT(a_grant_busy, clock, reset,
                     accept && (req.operation == OP_ALLOC),
                     busy_ff[rsp_ff.granted_reg])
   // A successful save advances the stack by one.
   `RBMS_ASSERT_NEXT(a_save_push, clock, reset,
                     accept && (req.operation == OP_SAVE) && (level_ff < LVL_FULL),
                     level_ff == $past(level_ff) + LVL_W'(1))

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Register busy map testbench
// Drives operation items into the busy map over the request channel and checks
// every result item against a cycle-free predictor of the map and its save
// stack. A directed table opens the run, then random phases with and without
// idling on both channels, including one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import rbms_pkg::*;

   localparam int ACTIVE_REGS = ACTIVE_REGS_DEFAULT;
   localparam int SAVE_DEPTH  = SAVE_DEPTH_DEFAULT;

   // Operation codes the block ignores; they still return an all-zero item.
   localparam logic [OP_W-1:0] OP_IGNORED_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_IGNORED_HI = 3'd7;

   localparam int PHASE_ITEMS     = 440;
   localparam int RSP_HOLD_CYCLES = 64;
   localparam int DRAIN_CYCLES    = 20;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int MAX_REPORTS     = 200;

   // Result items that can be read straight off the operation.
   localparam rsp_payload_type RSP_OK      = '{4'd0, 1'b1, 1'b0, 1'b0, 1'b0};
   localparam rsp_payload_type RSP_REFUSED = '{4'd0, 1'b0, 1'b0, 1'b0, 1'b0};
   localparam rsp_payload_type RSP_STK_ERR = '{4'd0, 1'b0, 1'b0, 1'b0, 1'b1};
   localparam rsp_payload_type RSP_RELOAD  = '{4'd0, 1'b1, 1'b0, 1'b1, 1'b0};
   localparam rsp_payload_type RSP_SPILL   = '{SPILL_REG, 1'b1, 1'b1, 1'b0, 1'b0};

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [REG_W-1:0] idx;
      logic             typed;   // use rsp below instead of the predictor
      rsp_payload_type  rsp;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 28;

   // Walk the corner cases from reset: bit 0 and index 15 handling, reload,
   // a completely full map and the spill, a full and an empty save stack,
   // and the two ignored operation codes.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_CLAIM,      4'd0,  1'b1, RSP_OK},
      '{OP_CLAIM,      4'd0,  1'b1, RSP_REFUSED},   // already busy
      '{OP_CLAIM,      4'd15, 1'b1, RSP_REFUSED},   // no such bit
      '{OP_RELEASE,    4'd0,  1'b1, RSP_REFUSED},
      '{OP_RELEASE,    4'd15, 1'b1, RSP_REFUSED},
      '{OP_RESTORE,    4'd3,  1'b1, RSP_STK_ERR},   // empty stack
      '{OP_RELEASE,    4'd10, 1'b1, RSP_RELOAD},
      '{OP_CLAIM,      4'd8,  1'b1, RSP_OK},
      '{OP_CLAIM,      4'd9,  1'b1, RSP_OK},
      '{OP_CLAIM,      4'd10, 1'b1, RSP_OK},
      '{OP_CLAIM,      4'd11, 1'b1, RSP_OK},
      '{OP_CLAIM,      4'd12, 1'b1, RSP_OK},
      '{OP_CLAIM,      4'd13, 1'b1, RSP_OK},
      '{OP_CLAIM,      4'd14, 1'b1, RSP_OK},
      '{OP_ALLOC,      4'd5,  1'b1, RSP_SPILL},     // nothing free
      '{OP_SAVE,       4'd0,  1'b1, RSP_OK},
      '{OP_SAVE,       4'd1,  1'b1, RSP_OK},
      '{OP_SAVE,       4'd2,  1'b1, RSP_OK},
      '{OP_SAVE,       4'd4,  1'b1, RSP_OK},
      '{OP_SAVE,       4'd8,  1'b1, RSP_OK},
      '{OP_SAVE,       4'd9,  1'b1, RSP_OK},
      '{OP_SAVE,       4'd12, 1'b1, RSP_OK},
      '{OP_SAVE,       4'd7,  1'b1, RSP_OK},
      '{OP_SAVE,       4'd15, 1'b1, RSP_STK_ERR},   // full stack
      '{OP_RESTORE,    4'd6,  1'b0, RSP_REFUSED},
      '{OP_CLEAR,      4'd15, 1'b1, RSP_OK},
      '{OP_IGNORED_LO, 4'd0,  1'b1, RSP_REFUSED},
      '{OP_IGNORED_HI, 4'd15, 1'b1, RSP_REFUSED}
   };

   logic clock;
   logic reset;

   rbms_stream_if #(.payload_type(req_payload_type)) req_ch ();
   rbms_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   register_busy_map_with_snapshots_top #(
      .ACTIVE_REGS (ACTIVE_REGS),
      .SAVE_DEPTH  (SAVE_DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Predicted state of the block.
   logic [MAP_W-1:0] predicted_map;
   logic [MAP_W-1:0] saved_map_stack [SAVE_DEPTH];
   int               stack_fill;

   rsp_payload_type  pending_outcomes [$];
   int               mismatches;
   int               defined_items;    // items with an operation the block acts on
   int               gap_pct;
   int               stall_pct;
   int               hold_requests;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Apply one operation to the predicted map and stack; return its result item.
   function automatic rsp_payload_type step_busy_map(input logic [OP_W-1:0] op,
                                                     input logic [REG_W-1:0] idx);
      rsp_payload_type  r;
      logic [MAP_W-1:0] active;
      r      = '0;
      active = '0;
      for (int k = 1; k < ACTIVE_REGS && k < MAP_W; k++) active[k] = 1'b1;
      case (op)
         OP_CLEAR: begin
            predicted_map &= ~active;
            r.success = 1'b1;
         end
         OP_ALLOC: begin
            // lowest free register from 1 upward
            for (int k = ACTIVE_REGS - 1; k >= 1; k--)
               if (!predicted_map[k]) r.granted_reg = REG_W'(k);
            if (r.granted_reg == '0) begin
               predicted_map &= ~LOW_SEVEN;
               r.spill_flag  = 1'b1;
               r.granted_reg = SPILL_REG;
            end
            predicted_map[r.granted_reg] = 1'b1;
            r.success = 1'b1;
         end
         OP_CLAIM: begin
            if (idx < MAP_W && !predicted_map[idx]) begin
               predicted_map[idx] = 1'b1;
               r.success = 1'b1;
            end
         end
         OP_RELEASE: begin
            if (idx >= 1 && idx < ACTIVE_REGS) begin
               predicted_map[idx] = 1'b0;
               r.success = 1'b1;
            end
            if (idx == RELOAD_REG) begin
               predicted_map |= LOW_SEVEN;
               r.reload_flag = 1'b1;
               r.success     = 1'b1;
            end
         end
         OP_SAVE: begin
            if (stack_fill < SAVE_DEPTH) begin
               saved_map_stack[stack_fill] = predicted_map;
               stack_fill++;
               r.success = 1'b1;
            end else begin
               r.stack_error = 1'b1;
            end
         end
         OP_RESTORE: begin
            if (stack_fill > 0) begin
               stack_fill--;
               predicted_map = saved_map_stack[stack_fill];
               r.success = 1'b1;
            end else begin
               r.stack_error = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one item, idle first at the current rate, and record the result
   // it owes once it is taken.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [REG_W-1:0] idx,
                            input logic typed, input rsp_payload_type typed_rsp);
      req_payload_type p;
      rsp_payload_type predicted;
      p.operation = op;
      p.reg_index = idx;
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      do @(posedge clock); while (!req_ch.ready);
      predicted = step_busy_map(op, idx);
      if (typed) predicted = typed_rsp;
      pending_outcomes = {pending_outcomes, predicted};
      if (op <= OP_RESTORE) defined_items++;
   endtask

   function automatic logic [OP_W-1:0] pick_op();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return OP_ALLOC;
      if (roll < 50) return OP_CLAIM;
      if (roll < 70) return OP_RELEASE;
      if (roll < 80) return OP_SAVE;
      if (roll < 90) return OP_RESTORE;
      if (roll < 95) return OP_CLEAR;
      return (roll < 98) ? OP_IGNORED_LO : OP_IGNORED_HI;
   endfunction

   // Mix single random items with bursts that fill the map, most of them to a spill, and
   // push the stack past both ends.
   task automatic run_phase(input int gap, input int stall, input int budget);
      int target;
      int roll;
      gap_pct   = gap;
      stall_pct = stall;
      target    = defined_items + budget;
      while (defined_items < target) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            send_item(OP_CLEAR, REG_W'($urandom_range(15)), 1'b0, '0);
            repeat (14 + $urandom_range(3))
               send_item(OP_ALLOC, REG_W'($urandom_range(15)), 1'b0, '0);
         end else if (roll < 11) begin
            repeat (SAVE_DEPTH + 1)
               send_item(OP_SAVE, REG_W'($urandom_range(15)), 1'b0, '0);
         end else if (roll < 16) begin
            repeat (SAVE_DEPTH + 2)
               send_item(OP_RESTORE, REG_W'($urandom_range(15)), 1'b0, '0);
         end else begin
            send_item(pick_op(), REG_W'($urandom_range(15)), 1'b0, '0);
         end
      end
   endtask

   task automatic check_field(input string name, input logic [REG_W-1:0] want,
                              input logic [REG_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Compare each result item with the oldest outstanding prediction.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result item with nothing outstanding, expected none, actual %p",
                        $time, rsp_ch.payload);
         end else begin
            want = pending_outcomes.pop_front();
            check_field("granted_reg", want.granted_reg, rsp_ch.payload.granted_reg);
            check_field("success",     want.success,     rsp_ch.payload.success);
            check_field("spill_flag",  want.spill_flag,  rsp_ch.payload.spill_flag);
            check_field("reload_flag", want.reload_flag, rsp_ch.payload.reload_flag);
            check_field("stack_error", want.stack_error, rsp_ch.payload.stack_error);
         end
      end
   end

   // Drop ready at the current stall rate; hold it low for a long stretch
   // whenever the stimulus asks, so the output register fills and the
   // request side backs up.
   initial begin : rsp_drain
      int hold_left;
      int served;
      hold_left = 0;
      served    = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served    = hold_requests;
            hold_left = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // End the run once nothing has moved on either channel for too long.
   always @(posedge clock) begin
      int quiet_cycles;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
         $display("register_busy_map_with_snapshots_top verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      mismatches    = 0;
      defined_items = 0;
      gap_pct       = 0;
      stall_pct     = 0;
      hold_requests = 0;
      predicted_map = '0;
      stack_fill    = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int row = 0; row < DIRECTED_ROWS; row++)
         send_item(directed_rows[row].op, directed_rows[row].idx,
                   directed_rows[row].typed, directed_rows[row].rsp);

      // Open the back-to-back phase with a long receiver hold-off.
      hold_requests++;
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(56, 0, PHASE_ITEMS);
      run_phase(0, 56, PHASE_ITEMS);
      run_phase(21, 21, PHASE_ITEMS);
      req_ch.valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("register_busy_map_with_snapshots_top verification clean");
      end else begin
         $display("register_busy_map_with_snapshots_top verification failed");
      end
      $finish;
   end

endmodule
